// ----- hdl/der_tag_length_header_parser_assert.svh -----
// ---------------------------------------------------------------------------
// DER header parser assertion macros
// Clocked property checks shared by the parser modules.
// ---------------------------------------------------------------------------
`ifndef DER_TAG_LENGTH_HEADER_PARSER_ASSERT_SVH
`define DER_TAG_LENGTH_HEADER_PARSER_ASSERT_SVH

// Check on clk_i, masked while reset is asserted.
`define DTHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on clk_i that must also hold during reset.
`define DTHP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hdl/dthp_pkg.sv -----
// ---------------------------------------------------------------------------
// DER header parser package
// Payload structs, status and phase codes, fixed field widths.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dthp_pkg;

  localparam int unsigned TagW       = 28;
  localparam int unsigned LenW       = 64;
  localparam int unsigned HdrW       = 4;
  localparam int unsigned QueueDepth = 2;

  localparam logic [4:0]      TagEscape = 5'h1f;
  localparam logic [7:0]      IndefLen  = 8'h80;
  localparam logic [HdrW-1:0] HdrMax    = 4'hf;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StIndef   = 2'd1,
    StLenLong = 2'd2,
    StTagLong = 2'd3
  } dthp_status_e;

  typedef enum logic [3:0] {
    PhIdle     = 4'b0001,
    PhTag      = 4'b0010,
    PhLenFirst = 4'b0100,
    PhLenMore  = 4'b1000
  } dthp_phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } dthp_in_t;

  typedef struct packed {
    logic [1:0]      tag_class;
    logic            constructed;
    logic [TagW-1:0] tag_number;
    logic [LenW-1:0] content_length;
    logic [HdrW-1:0] header_size;
    dthp_status_e    status;
  } dthp_out_t;

  // Byte plus pre-decoded flags, as queued between front and back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    logic       long_tag;      // identifier low bits are the escape value
    logic       more;          // bit 7: continuation / long-form length
    logic       indef;         // 0x80 length byte
    logic       len_too_long;  // long-form byte count above the limit
  } dthp_op_t;

endpackage

// ----- hdl/dthp_queue.sv -----
// ---------------------------------------------------------------------------
// DER header parser decoupling queue
// Small register FIFO between the classifier and the parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "der_tag_length_header_parser_assert.svh"

module dthp_queue
  import dthp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  dthp_op_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output dthp_op_t pop_data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  dthp_op_t        mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == CntW'(QueueDepth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `DTHP_ASSERT(a_q_no_overflow, !(push_i && full_o), "queue push while full")
  `DTHP_ASSERT(a_q_no_underflow, !(pop_i && empty_o), "queue pop while empty")
  `DTHP_ASSERT(a_q_count_bound, count_q <= CntW'(QueueDepth),
               "queue count out of range")

endmodule

// ----- hdl/dthp_front.sv -----
// ---------------------------------------------------------------------------
// DER header parser front end
// Takes input transfers and pre-decodes each byte for the parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dthp_front
  import dthp_pkg::*;
#(
  parameter int unsigned MAX_LENGTH_BYTES = 8
) (
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dthp_in_t in_item_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output dthp_op_t q_data_o
);

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_data_o.data_byte    = in_item_i.data_byte;
    q_data_o.restart      = in_item_i.restart;
    q_data_o.long_tag     = (in_item_i.data_byte[4:0] == TagEscape);
    q_data_o.more         = in_item_i.data_byte[7];
    q_data_o.indef        = (in_item_i.data_byte == IndefLen);
    q_data_o.len_too_long = (in_item_i.data_byte[6:0] > 7'(MAX_LENGTH_BYTES));
  end

endmodule

// ----- hdl/dthp_back.sv -----
// ---------------------------------------------------------------------------
// DER header parser back end
// Identifier/length state machine with a registered result stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "der_tag_length_header_parser_assert.svh"

module dthp_back
  import dthp_pkg::*;
#(
  parameter int unsigned MAX_TAG_GROUPS   = 4,
  parameter int unsigned MAX_LENGTH_BYTES = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      op_valid_i,
  input  dthp_op_t  op_i,
  output logic      op_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output dthp_out_t out_item_o
);

  localparam int unsigned GrpW  = $clog2(MAX_TAG_GROUPS + 2);
  localparam int unsigned LeftW = $clog2(MAX_LENGTH_BYTES + 1);

  dthp_phase_e      phase_q, phase_d, phase_eff;
  logic [1:0]       class_q, class_d;
  logic             cons_q, cons_d;
  logic [TagW-1:0]  tag_q, tag_d;
  logic [GrpW-1:0]  groups_q, groups_d, groups_nx;
  logic [LenW-1:0]  len_q, len_d;
  logic [LeftW-1:0] left_q, left_d, left_nx;
  logic [HdrW-1:0]  used_q, used_d, used_inc;

  logic             emit;
  logic [LenW-1:0]  emit_len;
  dthp_status_e     emit_status;

  logic             out_valid_q;
  dthp_out_t        out_item_q;

  // Step only when the result register is free or draining this cycle.
  assign op_pop_o = op_valid_i && (!out_valid_q || out_ready_i);

  assign phase_eff = op_i.restart ? PhIdle : phase_q;
  assign used_inc  = (used_q == HdrMax) ? used_q : used_q + 1'b1;
  assign groups_nx = groups_q + 1'b1;
  assign left_nx   = (left_q != '0) ? left_q - 1'b1 : left_q;

  always_comb begin
    phase_d     = phase_q;
    class_d     = class_q;
    cons_d      = cons_q;
    tag_d       = tag_q;
    groups_d    = groups_q;
    len_d       = len_q;
    left_d      = left_q;
    used_d      = used_q;
    emit        = 1'b0;
    emit_len    = '0;
    emit_status = StOk;
    if (op_pop_o) begin
      unique case (phase_eff)
        PhIdle: begin
          class_d  = op_i.data_byte[7:6];
          cons_d   = op_i.data_byte[5];
          groups_d = '0;
          len_d    = '0;
          left_d   = '0;
          used_d   = HdrW'(1);
          if (op_i.long_tag) begin
            tag_d   = '0;
            phase_d = PhTag;
          end else begin
            tag_d   = TagW'(op_i.data_byte[4:0]);
            phase_d = PhLenFirst;
          end
        end
        PhTag: begin
          used_d   = used_inc;
          groups_d = groups_nx;
          // group limit hit, or the next 7-bit shift would lose bits
          if (groups_nx > GrpW'(MAX_TAG_GROUPS) || tag_q[TagW-1:TagW-7] != '0) begin
            emit        = 1'b1;
            emit_status = StTagLong;
          end else begin
            tag_d = {tag_q[TagW-8:0], op_i.data_byte[6:0]};
            if (!op_i.more) begin
              phase_d = PhLenFirst;
            end
          end
        end
        PhLenFirst: begin
          used_d = used_inc;
          priority if (!op_i.more) begin
            emit     = 1'b1;
            emit_len = LenW'(op_i.data_byte);
          end else if (op_i.indef) begin
            emit        = 1'b1;
            emit_status = StIndef;
          end else if (op_i.len_too_long) begin
            emit        = 1'b1;
            emit_status = StLenLong;
          end else begin
            len_d   = '0;
            left_d  = LeftW'(op_i.data_byte[6:0]);
            phase_d = PhLenMore;
          end
        end
        PhLenMore: begin
          used_d = used_inc;
          len_d  = {len_q[LenW-9:0], op_i.data_byte};
          left_d = left_nx;
          if (left_nx == '0) begin
            emit     = 1'b1;
            emit_len = len_d;
          end
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
      if (emit) begin
        phase_d = PhIdle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      class_q     <= '0;
      cons_q      <= 1'b0;
      tag_q       <= '0;
      groups_q    <= '0;
      len_q       <= '0;
      left_q      <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      class_q  <= class_d;
      cons_q   <= cons_d;
      tag_q    <= tag_d;
      groups_q <= groups_d;
      len_q    <= len_d;
      left_q   <= left_d;
      used_q   <= used_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_item_q.tag_class      <= class_q;
      out_item_q.constructed    <= cons_q;
      out_item_q.tag_number     <= tag_q;
      out_item_q.content_length <= emit_len;
      out_item_q.header_size    <= used_d;
      out_item_q.status         <= emit_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `DTHP_ASSERT(a_back_emit_idle, emit |=> (phase_q == PhIdle), "no return to idle after result")
  `DTHP_ASSERT(a_back_hdr_nonzero, out_valid_q |-> (out_item_q.header_size != '0),
               "result with zero header size")
  `DTHP_ASSERT(a_back_err_len_zero,
               (out_valid_q && out_item_q.status != StOk) |-> (out_item_q.content_length == '0),
               "error result carries a length")

endmodule

// ----- hdl/der_tag_length_header_parser.sv -----
// The byte that ends the header is written into the queue; the parser step reads it there
// and loads the result into the output register, from which it transfers.
// Throughput: one byte per cycle while no result is held waiting in the output register.
// A result waiting in the output register stalls the parser only, and the queue keeps
// taking bytes until it fills.
// Reset (rst_ni low, asynchronous): parser idle, accumulators cleared, queue empty,
// no result valid.
// ---------------------------------------------------------------------------
// DER identifier and length header parser
// Byte-serial decoder for one X.690 tag/length header per result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module der_tag_length_header_parser
  import dthp_pkg::*;
#(
  parameter int unsigned MAX_TAG_GROUPS   = 4,  // long-form tag groups allowed
  parameter int unsigned MAX_LENGTH_BYTES = 8   // long-form length bytes allowed
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  // byte stream in
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dthp_in_t  in_item_i,
  // decoded headers out
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output dthp_out_t out_item_o
);

  // Front end: flow control and per-byte pre-decode (escape, continuation,
  // indefinite marker, length-count limit). No state of its own.
  logic     q_push;
  logic     q_full;
  dthp_op_t q_push_data;

  // Back end side of the queue.
  logic     q_pop;
  logic     q_empty;
  dthp_op_t q_pop_data;

  dthp_front #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_item_i (in_item_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_push_data)
  );

  // Two-entry queue: decouples input transfers from output stalls so that
  // a held result does not immediately block the byte stream.
  dthp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_push_data),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_data_o (q_pop_data)
  );

  // Back end: identifier -> tag groups -> length byte(s). One queued byte
  // per cycle while no result is held; a finished or failed header is
  // loaded into the result register and the parser drops back to idle.
  // Restart forces the byte to be read as a fresh identifier.
  dthp_back #(
    .MAX_TAG_GROUPS  (MAX_TAG_GROUPS),
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (!q_empty),
    .op_i       (q_pop_data),
    .op_pop_o   (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule
